@@ rtl/running_median_two_heaps_core_assert.svh @@
// assertion macros for the running median core
`ifndef RUNNING_MEDIAN_TWO_HEAPS_CORE_ASSERT_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RM_ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define RM_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define RM_ASSERT_IMPL(lbl, clk, rstn, prop)
`define RM_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

@@ rtl/rmth_pkg.sv @@
`default_nettype none
package rmth_pkg;
  localparam int unsigned HeapDepth = 512;
  localparam int unsigned AddrW = $clog2(HeapDepth);
  localparam int unsigned CntW = $clog2(HeapDepth + 1);

  typedef struct packed {
    logic signed [31:0] value;
    logic               restart;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] median;
    logic               rejected;
  } out_word_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD_KEY, OP_KEY_RD, OP_KEY_B, OP_LOAD_A, OP_LOAD_B
  } op_e;

  // command from controller to datapath
  typedef struct packed {
    logic             sel_upper;
    logic             mem_rd;
    logic [AddrW-1:0] rd_addr;
    logic             mem_wr;
    logic [AddrW-1:0] wr_addr;
    logic [1:0]       wr_src;
    op_e              op;
  } cmd_t;

  localparam logic [1:0] SrcKey = 2'd0;
  localparam logic [1:0] SrcA   = 2'd1;
  localparam logic [1:0] SrcRd  = 2'd2;

  typedef struct packed {
    logic signed [31:0] rd_data;
    logic signed [31:0] key;
    logic signed [31:0] reg_a;
  } stat_t;
endpackage
`default_nettype wire

@@ rtl/rmth_datapath.sv @@
`default_nettype none
module rmth_datapath (
  input  wire logic               clk_i,
  input  wire rmth_pkg::cmd_t     cmd_i,
  input  wire logic signed [31:0] in_value_i,
  output rmth_pkg::stat_t         stat_o
);
  logic signed [31:0] lo_mem [rmth_pkg::HeapDepth];
  logic signed [31:0] up_mem [rmth_pkg::HeapDepth];
  logic signed [31:0] lo_rd_q, up_rd_q, key_q, a_q, b_q, wdata, rd_data;
  logic               sel_q;

  assign rd_data = sel_q ? up_rd_q : lo_rd_q;

  always_comb begin
    case (cmd_i.wr_src)
      rmth_pkg::SrcA:  wdata = a_q;
      rmth_pkg::SrcRd: wdata = rd_data;
      default:         wdata = key_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr && !cmd_i.sel_upper) lo_mem[cmd_i.wr_addr] <= wdata;
    if (cmd_i.mem_rd) lo_rd_q <= lo_mem[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr && cmd_i.sel_upper) up_mem[cmd_i.wr_addr] <= wdata;
    if (cmd_i.mem_rd) up_rd_q <= up_mem[cmd_i.rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) sel_q <= cmd_i.sel_upper;
    case (cmd_i.op)
      rmth_pkg::OP_LOAD_KEY: key_q <= in_value_i;
      rmth_pkg::OP_KEY_RD:   key_q <= rd_data;
      rmth_pkg::OP_KEY_B:    key_q <= b_q;
      rmth_pkg::OP_LOAD_A:   a_q <= rd_data;
      rmth_pkg::OP_LOAD_B:   b_q <= rd_data;
      default: ;
    endcase
  end

  assign stat_o.rd_data = rd_data;
  assign stat_o.key     = key_q;
  assign stat_o.reg_a   = a_q;
endmodule
`default_nettype wire

@@ rtl/rmth_ctrl.sv @@
`default_nettype none
module rmth_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic                in_restart_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output rmth_pkg::out_word_t      out_word_o,
  output rmth_pkg::cmd_t           cmd_o,
  input  wire rmth_pkg::stat_t     stat_i,
  output logic [rmth_pkg::CntW-1:0] lo_cnt_o,
  output logic [rmth_pkg::CntW-1:0] up_cnt_o
);
  localparam int unsigned AW = rmth_pkg::AddrW;
  localparam int unsigned CW = rmth_pkg::CntW;
  localparam logic [CW-1:0] Full = CW'(rmth_pkg::HeapDepth);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_TOP     = 4'd1;
  localparam logic [3:0] S_PUSHW   = 4'd2;
  localparam logic [3:0] S_PUSHCMP = 4'd3;
  localparam logic [3:0] S_POPTOP  = 4'd4;
  localparam logic [3:0] S_POPLST  = 4'd5;
  localparam logic [3:0] S_POPKEY  = 4'd6;
  localparam logic [3:0] S_SDW     = 4'd7;
  localparam logic [3:0] S_SDR1    = 4'd8;
  localparam logic [3:0] S_SDC     = 4'd9;
  localparam logic [3:0] S_XFER    = 4'd10;
  localparam logic [3:0] S_MEDRD   = 4'd11;
  localparam logic [3:0] S_MEDW    = 4'd12;
  localparam logic [3:0] S_OUT     = 4'd13;

  logic [3:0]    st_q, st_d;
  logic [CW-1:0] lo_q, lo_d, up_q, up_d, n_q, n_d;
  logic [AW-1:0] i_q, i_d, c_q, c_d, par, bidx;
  logic          side_q, side_d, bal_q, bal_d, rej_q, rej_d;
  logic          out_v_q, out_v_d;
  logic signed [31:0] med_q, med_d, best;
  logic [CW:0]   ch1, ch2;
  logic          right_wins, child_wins, fin_push;

  // side 0 is lower max-heap
  function automatic logic above(input logic upper, input logic signed [31:0] x,
                                 input logic signed [31:0] y);
    above = upper ? (x < y) : (x > y);
  endfunction

  assign par = (i_q - AW'(1)) >> 1;
  assign ch1 = (CW+1)'({i_q, 1'b1});
  assign ch2 = (CW+1)'(c_q) + (CW+1)'(1);
  assign right_wins = above(side_q, stat_i.rd_data, stat_i.reg_a);
  assign best = right_wins ? stat_i.rd_data : stat_i.reg_a;
  assign bidx = right_wins ? c_q + AW'(1) : c_q;
  assign child_wins = above(side_q, best, stat_i.key);

  assign in_ready_o = (st_q == S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_word_o.median = med_q;
  assign out_word_o.rejected = rej_q;
  assign lo_cnt_o = lo_q;
  assign up_cnt_o = up_q;

  always_comb begin
    st_d = st_q; lo_d = lo_q; up_d = up_q; n_d = n_q; i_d = i_q; c_d = c_q;
    side_d = side_q; bal_d = bal_q; rej_d = rej_q; out_v_d = out_v_q; med_d = med_q;
    fin_push = 1'b0;
    cmd_o = '0;
    cmd_o.sel_upper = side_q;
    cmd_o.op = rmth_pkg::OP_NONE;
    cmd_o.wr_src = rmth_pkg::SrcKey;
    case (st_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = rmth_pkg::OP_LOAD_KEY;
          if (in_restart_i) begin
            lo_d = '0; up_d = '0;
          end
          if (!in_restart_i && lo_q == Full) begin
            rej_d = 1'b1; st_d = S_MEDRD;
          end else begin
            rej_d = 1'b0; bal_d = 1'b0;
            if (in_restart_i || lo_q == '0) begin
              side_d = 1'b0; i_d = '0; lo_d = CW'(1); st_d = S_PUSHW;
            end else begin
              cmd_o.sel_upper = 1'b0; cmd_o.mem_rd = 1'b1; cmd_o.rd_addr = '0;
              st_d = S_TOP;
            end
          end
        end
      end
      S_TOP: begin
        if ($signed(stat_i.key) < $signed(stat_i.rd_data)) begin
          side_d = 1'b0; i_d = lo_q[AW-1:0]; lo_d = lo_q + CW'(1);
        end else begin
          side_d = 1'b1; i_d = up_q[AW-1:0]; up_d = up_q + CW'(1);
        end
        st_d = S_PUSHW;
      end
      // sift up: key held, i is hole
      S_PUSHW: begin
        if (i_q == '0) begin
          cmd_o.mem_wr = 1'b1; cmd_o.wr_addr = i_q;
          fin_push = 1'b1;
        end else begin
          c_d = par;
          cmd_o.mem_rd = 1'b1; cmd_o.rd_addr = par;
          st_d = S_PUSHCMP;
        end
      end
      S_PUSHCMP: begin
        cmd_o.mem_wr = 1'b1; cmd_o.wr_addr = i_q;
        if (above(side_q, stat_i.key, stat_i.rd_data)) begin
          cmd_o.wr_src = rmth_pkg::SrcRd;
          i_d = c_q;
          st_d = S_PUSHW;
        end else begin
          fin_push = 1'b1;
        end
      end
      // pop: top goes to b, last becomes the sift key
      S_POPTOP: begin
        cmd_o.mem_rd = 1'b1; cmd_o.rd_addr = '0; st_d = S_POPLST;
      end
      S_POPLST: begin
        cmd_o.op = rmth_pkg::OP_LOAD_B;
        if (n_q == '0) begin
          st_d = S_XFER;
        end else begin
          cmd_o.mem_rd = 1'b1; cmd_o.rd_addr = n_q[AW-1:0]; st_d = S_POPKEY;
        end
      end
      S_POPKEY: begin
        cmd_o.op = rmth_pkg::OP_KEY_RD; i_d = '0; st_d = S_SDW;
      end
      // sift down: key held, i is hole
      S_SDW: begin
        if (ch1 >= {1'b0, n_q}) begin
          cmd_o.mem_wr = 1'b1; cmd_o.wr_addr = i_q; st_d = S_XFER;
        end else begin
          cmd_o.mem_rd = 1'b1; cmd_o.rd_addr = ch1[AW-1:0]; c_d = ch1[AW-1:0];
          st_d = S_SDR1;
        end
      end
      S_SDR1: begin
        cmd_o.op = rmth_pkg::OP_LOAD_A;
        if (ch2 < {1'b0, n_q}) begin
          cmd_o.mem_rd = 1'b1; cmd_o.rd_addr = c_q + AW'(1);
        end
        st_d = S_SDC;
      end
      S_SDC: begin
        cmd_o.mem_wr = 1'b1; cmd_o.wr_addr = i_q;
        if (child_wins) begin
          cmd_o.wr_src = right_wins ? rmth_pkg::SrcRd : rmth_pkg::SrcA;
          i_d = bidx; st_d = S_SDW;
        end else begin
          st_d = S_XFER;
        end
      end
      // push popped top onto the other heap
      S_XFER: begin
        cmd_o.op = rmth_pkg::OP_KEY_B;
        side_d = !side_q;
        if (side_q) begin
          i_d = lo_q[AW-1:0]; lo_d = lo_q + CW'(1);
        end else begin
          i_d = up_q[AW-1:0]; up_d = up_q + CW'(1);
        end
        st_d = S_PUSHW;
      end
      S_MEDRD: begin
        cmd_o.sel_upper = 1'b0; cmd_o.mem_rd = 1'b1; cmd_o.rd_addr = '0; st_d = S_MEDW;
      end
      S_MEDW: begin
        med_d = stat_i.rd_data; out_v_d = 1'b1; st_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) begin
          out_v_d = 1'b0; st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
    if (fin_push) begin
      st_d = S_MEDRD;
      if (!bal_q) begin
        if (lo_q < up_q) begin
          bal_d = 1'b1; side_d = 1'b1; n_d = up_q - CW'(1); up_d = up_q - CW'(1);
          st_d = S_POPTOP;
        end else if (lo_q > up_q + CW'(1)) begin
          bal_d = 1'b1; side_d = 1'b0; n_d = lo_q - CW'(1); lo_d = lo_q - CW'(1);
          st_d = S_POPTOP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; lo_q <= '0; up_q <= '0; n_q <= '0; i_q <= '0; c_q <= '0;
      side_q <= 1'b0; bal_q <= 1'b0; rej_q <= 1'b0; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; lo_q <= lo_d; up_q <= up_d; n_q <= n_d; i_q <= i_d; c_q <= c_d;
      side_q <= side_d; bal_q <= bal_d; rej_q <= rej_d; out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    med_q <= med_d;
  end
endmodule
`default_nettype wire

@@ rtl/running_median_two_heaps_core.sv @@
`default_nettype none
// Running lower median over two heaps in block memories (lower max-heap, upper
// min-heap, 512 entries each), one word at a time: in_ready_o is high only while idle.
// A restart word is pushed at once; otherwise the top of the lower heap picks a side,
// the value sifts up that heap, and a rebalance may follow that sifts down one heap
// and up the other; each memory has one read port with registered data, so sift-up
// reads the parent per level, sift-down both children. A held result adds its stall.
// Restart empties both heaps first; a full lower heap drops the value and flags it.
`include "running_median_two_heaps_core_assert.svh"
module running_median_two_heaps_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire rmth_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output rmth_pkg::out_word_t      out_word_o
);
  rmth_pkg::cmd_t  cmd;
  rmth_pkg::stat_t stat;
  logic [rmth_pkg::CntW-1:0] lo_cnt, up_cnt;
  logic bal_ok;

  rmth_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .in_restart_i(in_word_i.restart),
    .out_valid_o, .out_ready_i, .out_word_o,
    .cmd_o(cmd), .stat_i(stat), .lo_cnt_o(lo_cnt), .up_cnt_o(up_cnt)
  );

  rmth_datapath u_dp (
    .clk_i, .cmd_i(cmd), .in_value_i(in_word_i.value), .stat_o(stat)
  );

  assign bal_ok = (lo_cnt == up_cnt) || (lo_cnt == up_cnt + 1'b1);

  `RM_ASSERT_IMPL(a_balance, clk_i, rst_ni, in_ready_o |-> bal_ok)
  `RM_ASSERT_IMPL(a_excl, clk_i, rst_ni, !(in_ready_o && out_valid_o))
  `RM_ASSERT_NEXT(a_out_done, clk_i, rst_ni, out_valid_o && out_ready_i, in_ready_o)
endmodule
`default_nettype wire
